// ----- rtl/core/imu_pkg.sv -----
// ----------------------------------------------------------------------------
// imu_pkg
// Shared types and codes for the six-axis moving-average conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CHANNELS = 6;
	localparam int AXES     = 3;
	localparam int CFG_REGS = 3;

	typedef enum logic [1:0] {
		OP_CAL  = 2'd0,
		OP_FILT = 2'd1,
		OP_POLL = 2'd2,
		OP_RSVD = 2'd3
	} opcode_t;

	// Element 0 is accelerometer x, element 5 is gyro z.
	typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_vec_t;

	typedef struct packed {
		logic filt;
		logic cal_done;
	} stage_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/imu_six_axis_moving_average.sv -----
// ----------------------------------------------------------------------------
// imu_six_axis_moving_average
// Six-axis inertial sample conditioner: moving-average smoothing over a chain
// of history cells with running sums, gyro offset calibration and
// configurable accelerometer offsets.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   input     in_valid / in_stall     opcode, accel_x/y/z, gyro_x/y/z
//   output    out_valid / out_stall   out_accel_x/y/z, out_gyro_x/y/z, calibrated
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is taken every cycle while in_stall is low; its result passes
// the history update, the reciprocal multiply stage and the output register
// in that order. Reset clears the history cells, running sums and offsets
// at once. Each stage holds its item while the next one is full, so the
// input is only stalled when all stages and the output are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_six_axis_moving_average #(
	parameter int WINDOW_LENGTH       = 10,
	parameter int CALIBRATION_SAMPLES = 200
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [1:0]  opcode,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_accel_x,
	output logic signed [15:0] out_accel_y,
	output logic signed [15:0] out_accel_z,
	output logic signed [15:0] out_gyro_x,
	output logic signed [15:0] out_gyro_y,
	output logic signed [15:0] out_gyro_z,
	output logic               calibrated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data
);

	localparam int SW    = imu_pkg::SAMPLE_W;
	localparam int CH    = imu_pkg::CHANNELS;
	localparam int AX    = imu_pkg::AXES;
	localparam int SUM_W = SW + $clog2(WINDOW_LENGTH);
	localparam int CAL_W = SW + $clog2(CALIBRATION_SAMPLES + 1);
	localparam int CNT_W = $clog2(CALIBRATION_SAMPLES + 1);

	imu_pkg::sample_vec_t in_vec;
	imu_pkg::sample_vec_t tap [WINDOW_LENGTH];

	logic accept, push, cal_in, cal_last;
	logic s1_free, s1_move, s2_free, s2_move, out_free;
	logic v_s1, v_s2, out_valid_q;
	imu_pkg::stage_ctl_t ctl_s1, ctl_s2;

	logic signed [SUM_W-1:0] win_sum_q  [CH];
	logic signed [SUM_W-1:0] win_quo    [CH];
	logic signed [CAL_W-1:0] cal_sum_q  [AX];
	logic signed [CAL_W-1:0] cal_next   [AX];
	logic signed [CAL_W-1:0] cal_fin_s1 [AX];
	logic signed [CAL_W-1:0] cal_quo    [AX];
	logic        [CNT_W-1:0] cal_cnt_q;

	logic signed [SW-1:0] avg_q     [CH];
	logic signed [SW-1:0] avg_new   [CH];
	logic signed [SW-1:0] goff_q    [AX];
	logic signed [SW-1:0] goff_new  [AX];
	logic signed [SW-1:0] acc_off_q [AX];
	logic signed [SW-1:0] res_q     [CH];
	logic                 calibrated_q;
	logic                 cal_res_q;

	assign in_vec = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};

	// Stage flow control.
	assign out_free = !out_valid_q || !out_stall;
	assign s2_move  = v_s2 && out_free;
	assign s2_free  = !v_s2 || s2_move;
	assign s1_move  = v_s1 && s2_free;
	assign s1_free  = !v_s1 || s1_move;
	assign in_stall = !s1_free;
	assign accept   = in_valid && s1_free;
	assign push     = accept && (opcode == imu_pkg::OP_FILT);
	assign cal_in   = accept && (opcode == imu_pkg::OP_CAL);
	assign cal_last = cal_cnt_q == CNT_W'(CALIBRATION_SAMPLES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			ctl_s1      <= '0;
			ctl_s2      <= '0;
		end else begin
			if (s1_free) begin
				v_s1   <= in_valid;
				ctl_s1 <= '{filt: push, cal_done: cal_in && cal_last};
			end
			if (s2_free) begin
				v_s2   <= v_s1;
				ctl_s2 <= ctl_s1;
			end
			if (out_free) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// History chain: the newest sample enters the first cell.
	for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			imu_hist_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (push),
				.d        (in_vec),
				.q        (tap[i])
			);
		end else begin : g_body
			imu_hist_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (push),
				.d        (tap[i-1]),
				.q        (tap[i])
			);
		end
	end

	// Running window sums and the per-channel dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CH; c++) begin
				win_sum_q[c] <= '0;
			end
		end else if (push) begin
			for (int c = 0; c < CH; c++) begin
				win_sum_q[c] <= win_sum_q[c] + SUM_W'($signed(in_vec[c]))
					- SUM_W'($signed(tap[WINDOW_LENGTH-1][c]));
			end
		end
	end

	for (genvar c = 0; c < CH; c++) begin : g_win_div
		imu_cdiv #(
			.DIVISOR (WINDOW_LENGTH),
			.IN_W    (SUM_W)
		) u_div (
			.clk (clk),
			.en  (s1_move),
			.num (win_sum_q[c]),
			.quo (win_quo[c])
		);
	end

	// Gyro calibration sums.
	always_comb begin
		for (int c = 0; c < AX; c++) begin
			cal_next[c] = cal_sum_q[c] + CAL_W'($signed(in_vec[AX+c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cnt_q <= '0;
			for (int c = 0; c < AX; c++) begin
				cal_sum_q[c] <= '0;
			end
		end else if (cal_in) begin
			cal_cnt_q <= cal_last ? '0 : cal_cnt_q + 1'b1;
			for (int c = 0; c < AX; c++) begin
				cal_sum_q[c] <= cal_last ? '0 : cal_next[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cal_in && cal_last) begin
			for (int c = 0; c < AX; c++) begin
				cal_fin_s1[c] <= cal_next[c];
			end
		end
	end

	for (genvar c = 0; c < AX; c++) begin : g_cal_div
		imu_cdiv #(
			.DIVISOR (CALIBRATION_SAMPLES),
			.IN_W    (CAL_W)
		) u_div (
			.clk (clk),
			.en  (s1_move),
			.num (cal_fin_s1[c]),
			.quo (cal_quo[c])
		);
	end

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < AX; c++) begin
				acc_off_q[c] <= '0;
			end
		end else if (cfg_valid && (cfg_index < 2'(imu_pkg::CFG_REGS))) begin
			acc_off_q[cfg_index] <= $signed(cfg_data);
		end
	end

	// Held averages, offsets and the output register.
	always_comb begin
		for (int c = 0; c < CH; c++) begin
			avg_new[c] = ctl_s2.filt ? win_quo[c][SW-1:0] : avg_q[c];
		end
		for (int c = 0; c < AX; c++) begin
			goff_new[c] = ctl_s2.cal_done ? cal_quo[c][SW-1:0] : goff_q[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calibrated_q <= 1'b0;
			for (int c = 0; c < CH; c++) begin
				avg_q[c] <= '0;
			end
			for (int c = 0; c < AX; c++) begin
				goff_q[c] <= '0;
			end
		end else if (s2_move) begin
			calibrated_q <= calibrated_q || ctl_s2.cal_done;
			avg_q        <= avg_new;
			goff_q       <= goff_new;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			cal_res_q <= calibrated_q || ctl_s2.cal_done;
			for (int c = 0; c < AX; c++) begin
				res_q[c]    <= avg_new[c] - acc_off_q[c];
				res_q[AX+c] <= avg_new[AX+c] - goff_new[c];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_accel_x = res_q[0];
	assign out_accel_y = res_q[1];
	assign out_accel_z = res_q[2];
	assign out_gyro_x  = res_q[3];
	assign out_gyro_y  = res_q[4];
	assign out_gyro_z  = res_q[5];
	assign calibrated  = cal_res_q;

	// Once calibrated, the flag stays set.
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		calibrated_q |=> calibrated_q)
		else $error("calibrated flag dropped");

	// The calibration count never reaches the run length.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_cnt_q < CNT_W'(CALIBRATION_SAMPLES))
		else $error("calibration count out of range");

	// The last sample of a run clears the count and marks its item as complete.
	a_cal_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cal_in && cal_last) |=> (cal_cnt_q == '0 && v_s1 && ctl_s1.cal_done))
		else $error("calibration run did not complete");

	// The input is only stalled when every stage and the output are occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_valid_q && out_stall))
		else $error("input stalled with a free stage");

	// A held first-stage item is not lost.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_move) |=> v_s1)
		else $error("first-stage item dropped");

endmodule

`default_nettype wire

// ----- rtl/core/imu_hist_cell.sv -----
// ----------------------------------------------------------------------------
// imu_hist_cell
// One position of the sample history, holding all six channels and passing
// them on to the next cell whenever a filtered sample enters.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_hist_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift_en,
	input  imu_pkg::sample_vec_t d,
	output imu_pkg::sample_vec_t q
);

	imu_pkg::sample_vec_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift_en) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/imu_cdiv.sv -----
// ----------------------------------------------------------------------------
// imu_cdiv
// Signed division by a constant, truncating toward zero, by multiplication
// with a rounded-up reciprocal. The product is registered; the quotient and
// its sign are recovered after the register.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_cdiv #(
	parameter int DIVISOR = 10,
	parameter int IN_W    = 20
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [IN_W-1:0] num,
	output logic signed [IN_W-1:0] quo
);

	localparam int SHIFT   = IN_W + $clog2(DIVISOR);
	localparam int RECIP_W = IN_W + 1;
	localparam int PROD_W  = IN_W + RECIP_W;
	localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

	logic [IN_W-1:0]   mag;
	logic [PROD_W-1:0] prod_s2;
	logic              neg_s2;
	logic [IN_W-1:0]   mag_quo;

	assign mag = num[IN_W-1] ? IN_W'(-num) : IN_W'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(RECIP[RECIP_W-1:0]);
			neg_s2  <= num[IN_W-1];
		end
	end

	assign mag_quo = IN_W'(prod_s2 >> SHIFT);
	assign quo     = neg_s2 ? -$signed(mag_quo) : $signed(mag_quo);

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the six-axis moving-average conditioner. A queue of
// pending transfers, register writes and drain points feeds a clocked driver;
// a clocked monitor predicts every accepted sample, including the history
// window, the gyro calibration runs and the accelerometer offsets, and checks
// each result in order. Both sides idle at random, with bursts of no idling.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN         = 10;
	localparam int CAL_N       = 200;
	localparam int TOTAL_ITEMS = 1800;
	localparam int MAX_WAIT    = 11;
	localparam int REPORT_MAX  = 10;
	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE      = 20;

	localparam logic [1:0] REG_ACCEL_OFS_X = 2'd0;
	localparam logic [1:0] REG_ACCEL_OFS_Y = 2'd1;
	localparam logic [1:0] REG_ACCEL_OFS_Z = 2'd2;
	localparam logic [1:0] REG_SPARE       = 2'd3;

	localparam logic [15:0] S16_MAX = 16'h7FFF;
	localparam logic [15:0] S16_MIN = 16'h8000;

	typedef struct packed {
		imu_pkg::opcode_t     op;
		imu_pkg::sample_vec_t raw;
	} imu_item_t;

	typedef struct packed {
		imu_pkg::sample_vec_t value;
		logic                 cal;
	} imu_result_t;

	typedef enum logic [1:0] {
		ACT_ITEM,
		ACT_WRITE,
		ACT_DRAIN,
		ACT_END
	} action_kind_t;

	typedef struct packed {
		action_kind_t kind;
		imu_item_t    item;
		logic [1:0]   reg_idx;
		logic [15:0]  reg_val;
	} action_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = imu_pkg::OP_POLL;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic signed [15:0] gyro_x = '0;
	logic signed [15:0] gyro_y = '0;
	logic signed [15:0] gyro_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] out_accel_x;
	logic signed [15:0] out_accel_y;
	logic signed [15:0] out_accel_z;
	logic signed [15:0] out_gyro_x;
	logic signed [15:0] out_gyro_y;
	logic signed [15:0] out_gyro_z;
	logic calibrated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_ACCEL_OFS_X;
	logic [15:0] cfg_data = '0;

	imu_six_axis_moving_average #(
		.WINDOW_LENGTH(WIN),
		.CALIBRATION_SAMPLES(CAL_N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.gyro_x(gyro_x),
		.gyro_y(gyro_y),
		.gyro_z(gyro_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_accel_x(out_accel_x),
		.out_accel_y(out_accel_y),
		.out_accel_z(out_accel_z),
		.out_gyro_x(out_gyro_x),
		.out_gyro_y(out_gyro_y),
		.out_gyro_z(out_gyro_z),
		.calibrated(calibrated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	action_t     actions [$];
	imu_result_t conditioned_q [$];
	int          in_flight = 0;
	logic        stim_done = 1'b0;
	int          fail_count = 0;
	int          item_total = 0;
	int          tx_gap = 0;
	bit          tx_burst = 1'b0;
	int          rx_wait = 0;
	bit          rx_burst = 1'b0;
	int          idle_cycles = 0;

	shortint sample_hist [imu_pkg::CHANNELS][WIN];
	shortint window_avg [imu_pkg::CHANNELS];
	shortint gyro_ofs [imu_pkg::AXES];
	shortint accel_ofs [imu_pkg::AXES];
	int      cal_sum [imu_pkg::AXES];
	int      cal_count = 0;
	bit      cal_flag = 1'b0;

	string chan_label [imu_pkg::CHANNELS] = '{"out_accel_x", "out_accel_y", "out_accel_z",
		"out_gyro_x", "out_gyro_y", "out_gyro_z"};

	function automatic imu_result_t predict_conditioned(input imu_item_t it);
		imu_result_t r;
		int sum;
		case (it.op)
		imu_pkg::OP_CAL: begin
			for (int a = 0; a < imu_pkg::AXES; a++)
				cal_sum[a] += shortint'(it.raw[imu_pkg::AXES + a]);
			cal_count++;
			if (cal_count >= CAL_N) begin
				for (int a = 0; a < imu_pkg::AXES; a++) begin
					gyro_ofs[a] = shortint'(cal_sum[a] / CAL_N);
					cal_sum[a] = 0;
				end
				cal_count = 0;
				cal_flag = 1'b1;
			end
		end
		imu_pkg::OP_FILT: begin
			for (int c = 0; c < imu_pkg::CHANNELS; c++) begin
				sum = 0;
				for (int k = 0; k < WIN - 1; k++)
					sample_hist[c][k] = sample_hist[c][k + 1];
				sample_hist[c][WIN - 1] = shortint'(it.raw[c]);
				for (int k = 0; k < WIN; k++)
					sum += sample_hist[c][k];
				window_avg[c] = shortint'(sum / WIN);
			end
		end
		default: ;
		endcase
		for (int a = 0; a < imu_pkg::AXES; a++) begin
			r.value[a] = window_avg[a] - accel_ofs[a];
			r.value[imu_pkg::AXES + a] = window_avg[imu_pkg::AXES + a] - gyro_ofs[a];
		end
		r.cal = cal_flag;
		return r;
	endfunction

	task automatic note_failure(input string msg);
		if (fail_count < REPORT_MAX)
			$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic add_item(input imu_pkg::opcode_t op, input imu_pkg::sample_vec_t raw);
		action_t act;
		act = '0;
		act.kind = ACT_ITEM;
		act.item.op = op;
		act.item.raw = raw;
		actions.push_back(act);
		item_total++;
	endtask

	task automatic add_marker(input action_kind_t kind);
		action_t act;
		act = '0;
		act.kind = kind;
		actions.push_back(act);
	endtask

	// Offsets are only changed once every expected result has come back.
	task automatic add_write(input logic [1:0] idx, input logic [15:0] val);
		action_t act;
		add_marker(ACT_DRAIN);
		act = '0;
		act.kind = ACT_WRITE;
		act.reg_idx = idx;
		act.reg_val = val;
		actions.push_back(act);
	endtask

	function automatic imu_pkg::sample_vec_t uniform(input logic [15:0] a,
		input logic [15:0] g);
		return {g, g, g, a, a, a};
	endfunction

	function automatic logic [15:0] draw_sample(input int centre);
		case ($urandom_range(0, 7))
		0: return S16_MIN;
		1: return S16_MAX;
		2, 3: return 16'(centre + $urandom_range(0, 512) - 256);
		default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		action_t act;
		logic nxt_valid;
		logic nxt_cfg;
		if (arst_n) begin
			nxt_valid = in_valid && in_stall;
			nxt_cfg = cfg_valid && !cfg_ready;
			if (in_valid && !in_stall) begin
				tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 63) == 0)
					tx_burst = !tx_burst;
			end
			if (!nxt_valid && !nxt_cfg) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (actions.size() > 0) begin
					act = actions[0];
					case (act.kind)
					ACT_ITEM: begin
						opcode <= act.item.op;
						accel_x <= act.item.raw[0];
						accel_y <= act.item.raw[1];
						accel_z <= act.item.raw[2];
						gyro_x <= act.item.raw[3];
						gyro_y <= act.item.raw[4];
						gyro_z <= act.item.raw[5];
						nxt_valid = 1'b1;
						void'(actions.pop_front());
					end
					ACT_WRITE: begin
						cfg_index <= act.reg_idx;
						cfg_data <= act.reg_val;
						nxt_cfg = 1'b1;
						void'(actions.pop_front());
					end
					ACT_DRAIN: begin
						if (!in_valid && !cfg_valid && in_flight == 0)
							void'(actions.pop_front());
					end
					default: begin
						stim_done <= 1'b1;
						void'(actions.pop_front());
					end
					endcase
				end
			end
			in_valid <= nxt_valid;
			cfg_valid <= nxt_cfg;
		end
	end

	always @(posedge clk) begin
		imu_item_t cur;
		imu_result_t got;
		imu_result_t want;
		int n;
		if (arst_n) begin
			n = in_flight;
			if (out_valid && !out_stall) begin
				got.value = {out_gyro_z, out_gyro_y, out_gyro_x,
					out_accel_z, out_accel_y, out_accel_x};
				got.cal = calibrated;
				if (conditioned_q.size() == 0) begin
					note_failure("result transfer with no expected result waiting");
				end else begin
					want = conditioned_q.pop_front();
					n--;
					for (int c = 0; c < imu_pkg::CHANNELS; c++)
						if (got.value[c] !== want.value[c])
							note_failure($sformatf("%s: expected %0d, got %0d",
								chan_label[c], $signed(want.value[c]),
								$signed(got.value[c])));
					if (got.cal !== want.cal)
						note_failure($sformatf("calibrated: expected %0b, got %0b",
							want.cal, got.cal));
				end
				rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 63) == 0)
					rx_burst = !rx_burst;
			end
			if (cfg_valid && cfg_ready && cfg_index != REG_SPARE)
				accel_ofs[cfg_index] = shortint'(cfg_data);
			if (in_valid && !in_stall) begin
				cur.op = imu_pkg::opcode_t'(opcode);
				cur.raw = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};
				conditioned_q.push_back(predict_conditioned(cur));
				n++;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			in_flight <= n;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		int len;
		int centre [imu_pkg::CHANNELS];
		imu_pkg::opcode_t op;
		imu_pkg::sample_vec_t raw;

		add_item(imu_pkg::OP_POLL, {$urandom, $urandom, $urandom});
		add_item(imu_pkg::OP_RSVD, '1);
		repeat (4) add_item(imu_pkg::OP_FILT, uniform(S16_MAX, S16_MAX));
		repeat (4) add_item(imu_pkg::OP_FILT, uniform(S16_MIN, S16_MIN));
		repeat (2) add_item(imu_pkg::OP_FILT, uniform(S16_MAX, S16_MIN));
		add_item(imu_pkg::OP_FILT, uniform(16'hFFFF, 16'h0001));
		repeat (3) add_item(imu_pkg::OP_CAL, uniform(16'h0000, S16_MAX));
		repeat (3) add_item(imu_pkg::OP_CAL, uniform(16'h0000, S16_MIN));
		add_item(imu_pkg::OP_POLL, '0);
		add_write(REG_ACCEL_OFS_X, S16_MIN);
		add_write(REG_ACCEL_OFS_Y, S16_MAX);
		add_write(REG_ACCEL_OFS_Z, 16'hFFFF);
		add_write(REG_SPARE, 16'($urandom));
		add_item(imu_pkg::OP_POLL, '0);
		add_item(imu_pkg::OP_FILT, uniform(S16_MAX, S16_MIN));
		add_item(imu_pkg::OP_RSVD, {$urandom, $urandom, $urandom});

		while (item_total < TOTAL_ITEMS) begin
			kind = $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4))
					add_write(2'($urandom_range(0, 3)), draw_sample(0));
			for (int c = 0; c < imu_pkg::CHANNELS; c++)
				centre[c] = $urandom_range(0, 65535) - 32768;
			len = $urandom_range(20, 160);
			for (int j = 0; j < len; j++) begin
				case (kind)
				0, 1: op = ($urandom_range(0, 9) != 0) ? imu_pkg::OP_CAL
					: imu_pkg::opcode_t'($urandom_range(0, 3));
				2: op = ($urandom_range(0, 9) != 0) ? imu_pkg::OP_FILT
					: imu_pkg::opcode_t'($urandom_range(0, 3));
				default: op = imu_pkg::opcode_t'($urandom_range(0, 3));
				endcase
				for (int c = 0; c < imu_pkg::CHANNELS; c++)
					raw[c] = draw_sample(centre[c]);
				add_item(op, raw);
			end
		end
		add_marker(ACT_DRAIN);
		add_marker(ACT_END);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(posedge clk); while (!stim_done);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
